@@ sv/assert_macros.svh @@
// Assertion macros for the tracker RTL (used by the table engine).
// Depends on clock and reset being in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define RRT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked at every edge, reset included
`define RRT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

@@ sv/rrt_pkg.sv @@
// Types and constants of the retry request tracker.
// No dependencies; used by all tracker modules except rrt_ram.
`timescale 1ns / 1ps

package rrt_pkg;

   localparam int RRT_SLOTS       = 16;
   localparam int RRT_QUEUE_DEPTH = 2;
   localparam int RRT_QPTR_W      = (RRT_QUEUE_DEPTH > 1) ? $clog2(RRT_QUEUE_DEPTH) : 1;
   localparam int RRT_QCNT_W      = $clog2(RRT_QUEUE_DEPTH + 1);

   localparam int ID_W   = 16;
   localparam int TRY_W  = 4;
   localparam int IP_W   = 32;
   localparam int PROTO_W = 8;
   localparam int CSR_W  = 32;
   localparam int SLOT_OUT_W = 4;

   localparam logic [ID_W-1:0]    RRT_FIRST_ID   = 16'd1001;
   localparam logic [TRY_W-1:0]   RRT_LIMIT_RST  = 4'd4;
   localparam logic [PROTO_W-1:0] RRT_PROTO_RST  = 8'd254;

   typedef enum logic [1:0] {
      OP_ISSUE    = 2'd0,
      OP_TICK     = 2'd1,
      OP_RESPONSE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_RETRY_LIMIT = 2'd0,
      CSR_SERVER_ADDR = 2'd1,
      CSR_CLIENT_ADDR = 2'd2,
      CSR_PROTOCOL    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_ALLOC      = 3'd0,
      KIND_FULL       = 3'd1,
      KIND_RETRANSMIT = 3'd2,
      KIND_TIMEOUT    = 3'd3,
      KIND_MATCH      = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CMD_ISSUE = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_RESP  = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type      op;
      logic [ID_W-1:0] rid;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [TRY_W-1:0] tries;
   } slot_entry_type;

endpackage

@@ sv/rrt_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rrt_front.sv @@
// Front end: configuration registers, input handshake and classification.
// Depends on rrt_pkg.
`timescale 1ns / 1ps

module rrt_front import rrt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wr_data,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [ID_W-1:0]    req_response_id,
   input  logic [IP_W-1:0]    req_source_address,
   input  logic [IP_W-1:0]    req_dest_address,
   input  logic [PROTO_W-1:0] req_proto_field,
   input  logic               req_is_response,
   input  logic               q_full,
   output logic               q_push,
   output cmd_type            q_cmd,
   output logic [TRY_W-1:0]   retry_limit
);

   logic [TRY_W-1:0]   retry_limit_ff, retry_limit_in;
   logic [IP_W-1:0]    server_addr_ff, server_addr_in;
   logic [IP_W-1:0]    client_addr_ff, client_addr_in;
   logic [PROTO_W-1:0] protocol_ff, protocol_in;
   logic               accept;
   logic               resp_pass;

   always_comb begin
      retry_limit_in = retry_limit_ff;
      server_addr_in = server_addr_ff;
      client_addr_in = client_addr_ff;
      protocol_in    = protocol_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RETRY_LIMIT: retry_limit_in = csr_wr_data[TRY_W-1:0];
            CSR_SERVER_ADDR: server_addr_in = csr_wr_data[IP_W-1:0];
            CSR_CLIENT_ADDR: client_addr_in = csr_wr_data[IP_W-1:0];
            CSR_PROTOCOL:    protocol_in    = csr_wr_data[PROTO_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RRT_LIMIT_RST;
         server_addr_ff <= '0;
         client_addr_ff <= '0;
         protocol_ff    <= RRT_PROTO_RST;
      end else begin
         retry_limit_ff <= retry_limit_in;
         server_addr_ff <= server_addr_in;
         client_addr_ff <= client_addr_in;
         protocol_ff    <= protocol_in;
      end
   end

   assign busy        = q_full;
   assign accept      = start && !q_full;
   assign retry_limit = retry_limit_ff;

   assign resp_pass = (req_source_address == server_addr_ff) &&
                      (req_dest_address == client_addr_ff) &&
                      (req_proto_field == protocol_ff) && req_is_response;

   always_comb begin
      q_push     = 1'b0;
      q_cmd.op   = CMD_ISSUE;
      q_cmd.rid  = req_response_id;
      unique case (req_opcode)
         OP_ISSUE: begin
            q_push   = accept;
            q_cmd.op = CMD_ISSUE;
         end
         OP_TICK: begin
            q_push   = accept;
            q_cmd.op = CMD_TICK;
         end
         OP_RESPONSE: begin
            q_push   = accept && resp_pass;
            q_cmd.op = CMD_RESP;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/rrt_queue.sv @@
// Short command queue between the front end and the table engine.
// Depends on rrt_pkg.
`timescale 1ns / 1ps

module rrt_queue import rrt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   push_cmd,
   input  logic      pop,
   output logic      full,
   output qhead_type head
);

   cmd_type                entries_ff [RRT_QUEUE_DEPTH];
   logic [RRT_QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RRT_QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RRT_QCNT_W-1:0]  count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == RRT_QCNT_W'(RRT_QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == RRT_QPTR_W'(RRT_QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == RRT_QPTR_W'(RRT_QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ sv/rrt_back.sv @@
// Table engine: slot valid bits, slot RAM walk, id counter and result register.
// Depends on rrt_pkg, rrt_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrt_back import rrt_pkg::*; #(
   parameter int SLOTS = RRT_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  qhead_type             q_head,
   output logic                  q_pop,
   input  logic [TRY_W-1:0]      retry_limit,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_kind,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [ID_W-1:0]       rsp_request_id,
   output logic [TRY_W-1:0]      rsp_try_count,
   output logic                  rsp_last
);

   localparam int IDX_W = $clog2(SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type       state_ff, state_in;
   cmd_op_type      mode_ff, mode_in;
   logic [ID_W-1:0] rid_ff, rid_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [ID_W-1:0] next_id_ff, next_id_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [TRY_W-1:0]      rsp_tries_ff, rsp_tries_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic             ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   slot_entry_type   ram_wr_data, ram_rd_data;

   logic [IDX_W-1:0] free_idx;
   logic             have_free;
   logic             hit, none_above, at_end, id_match, walk_done;

   rrt_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign have_free  = ~&valid_ff;
   assign hit        = valid_ff[cur_ff];
   assign none_above = ((valid_ff >> cur_ff) >> 1) == '0;
   assign at_end     = (cur_ff == IDX_W'(SLOTS - 1));
   assign id_match   = hit && (ram_rd_data.id == rid_ff);
   assign walk_done  = none_above || at_end || ((mode_ff == CMD_RESP) && id_match);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      rid_in       = rid_ff;
      cur_in       = cur_ff;
      valid_in     = valid_ff;
      next_id_in   = next_id_ff;
      q_pop        = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_ALLOC;
      rsp_slot_in  = SLOT_OUT_W'(cur_ff);
      rsp_id_in    = ram_rd_data.id;
      rsp_tries_in = '0;
      rsp_last_in  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               unique case (q_head.cmd.op)
                  CMD_ISSUE: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_id_in    = next_id_ff;
                     if (have_free) begin
                        valid_in[free_idx] = 1'b1;
                        ram_wr_en          = 1'b1;
                        ram_wr_addr        = free_idx;
                        ram_wr_data.id     = next_id_ff;
                        ram_wr_data.tries  = TRY_W'(1);
                        rsp_kind_in        = KIND_ALLOC;
                        rsp_slot_in        = SLOT_OUT_W'(free_idx);
                        rsp_tries_in       = TRY_W'(1);
                        next_id_in         = next_id_ff + 1'b1;
                     end else begin
                        rsp_kind_in = KIND_FULL;
                        rsp_slot_in = '0;
                     end
                  end
                  CMD_TICK, CMD_RESP: begin
                     if (valid_ff != '0) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        cur_in      = '0;
                        mode_in     = q_head.cmd.op;
                        rid_in      = q_head.cmd.rid;
                        state_in    = ST_WALK;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (mode_ff == CMD_TICK) begin
               if (hit) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = none_above;
                  if (ram_rd_data.tries == retry_limit) begin
                     valid_in[cur_ff] = 1'b0;
                     rsp_kind_in      = KIND_TIMEOUT;
                  end else begin
                     ram_wr_en         = 1'b1;
                     ram_wr_data.tries = ram_rd_data.tries + 1'b1;
                     rsp_kind_in       = KIND_RETRANSMIT;
                     rsp_tries_in      = ram_rd_data.tries + 1'b1;
                  end
               end
            end else if (id_match) begin
               valid_in[cur_ff] = 1'b0;
               rsp_valid_in     = 1'b1;
               rsp_last_in      = 1'b1;
               rsp_kind_in      = KIND_MATCH;
               rsp_id_in        = rid_ff;
            end
            if (walk_done) begin
               state_in = ST_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cur_ff + 1'b1;
               cur_in      = cur_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         next_id_ff   <= RRT_FIRST_ID;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      rid_ff       <= rid_in;
      cur_ff       <= cur_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_tries_ff <= rsp_tries_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_request_id = rsp_id_ff;
   assign rsp_try_count  = rsp_tries_ff;
   assign rsp_last       = rsp_last_ff;

   `RRT_ASSERT(a_full_only_when_all_valid,
      (rsp_valid_ff && rsp_kind_ff == KIND_FULL) |-> (&valid_ff),
      "table full reported while a slot is free")
   `RRT_ASSERT(a_one_alloc_per_cycle,
      $countones(valid_ff) <= $countones($past(valid_ff)) + 1,
      "more than one slot allocated in a cycle")
   `RRT_ASSERT(a_more_results_in_walk,
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == ST_WALK),
      "non-final result without a walk in progress")
   `RRT_ASSERT_ALWAYS(a_reset_clears_table,
      reset |=> (valid_ff == '0 && next_id_ff == RRT_FIRST_ID && !rsp_valid_ff),
      "table not cleared by reset")

endmodule

@@ sv/retry_request_tracker.sv @@
// Retry request tracker top level: front end, command queue and table engine.
// Depends on rrt_pkg, rrt_front, rrt_queue and rrt_back.
//
//   channel   handshake                       payload
//   request   start / busy                    req_opcode .. req_is_response
//   response  rsp_valid, one-cycle strobe     rsp_kind .. rsp_last
//   csr       csr_wr_en, no wait              csr_index, csr_wr_data
//
// Issue: queued, then the result is registered. Tick and response: one slot RAM
// read per cycle, ending after the last valid slot or the match.
// A filtered response or unused opcode is dropped at the front and gives no result.
// Reset clears the valid bits at once; no clearing pass, slot RAM is not reset.
// busy rises when the two-entry command queue is full; results cannot be held off.
`timescale 1ns / 1ps

module retry_request_tracker import rrt_pkg::*; #(
   parameter int SLOTS = RRT_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_W-1:0]      csr_wr_data,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [ID_W-1:0]       req_response_id,
   input  logic [IP_W-1:0]       req_source_address,
   input  logic [IP_W-1:0]       req_dest_address,
   input  logic [PROTO_W-1:0]    req_proto_field,
   input  logic                  req_is_response,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_kind,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [ID_W-1:0]       rsp_request_id,
   output logic [TRY_W-1:0]      rsp_try_count,
   output logic                  rsp_last
);

   logic             q_full, q_push, q_pop;
   cmd_type          q_cmd;
   qhead_type        q_head;
   logic [TRY_W-1:0] retry_limit;

   rrt_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_response_id    (req_response_id),
      .req_source_address (req_source_address),
      .req_dest_address   (req_dest_address),
      .req_proto_field    (req_proto_field),
      .req_is_response    (req_is_response),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_cmd              (q_cmd),
      .retry_limit        (retry_limit)
   );

   rrt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .head     (q_head)
   );

   rrt_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .retry_limit    (retry_limit),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_slot       (rsp_slot),
      .rsp_request_id (rsp_request_id),
      .rsp_try_count  (rsp_try_count),
      .rsp_last       (rsp_last)
   );

endmodule

@@ tb/rrt_checker.sv @@
// Scoreboard for the retry request tracker: mirrors the slot table, predicts
// each transaction's results and compares them with the response port.
// Depends on rrt_pkg.
`timescale 1ns / 1ps

module rrt_checker import rrt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_W-1:0]      csr_wr_data,
   input  logic                  start,
   input  logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [ID_W-1:0]       req_response_id,
   input  logic [IP_W-1:0]       req_source_address,
   input  logic [IP_W-1:0]       req_dest_address,
   input  logic [PROTO_W-1:0]    req_proto_field,
   input  logic                  req_is_response,
   input  logic                  rsp_valid,
   input  logic [2:0]            rsp_kind,
   input  logic [SLOT_OUT_W-1:0] rsp_slot,
   input  logic [ID_W-1:0]       rsp_request_id,
   input  logic [TRY_W-1:0]      rsp_try_count,
   input  logic                  rsp_last,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct packed {
      kind_type               kind;
      logic [SLOT_OUT_W-1:0]  slot;
      logic [ID_W-1:0]        id;
      logic [TRY_W-1:0]       tries;
      logic                   last;
   } tracker_event_type;

   tracker_event_type    expected_q[$];
   logic                 slot_live  [RRT_SLOTS];
   logic [ID_W-1:0]      slot_req_id[RRT_SLOTS];
   logic [TRY_W-1:0]     slot_tries [RRT_SLOTS];
   logic [ID_W-1:0]      id_counter;
   logic [TRY_W-1:0]     retry_limit;
   logic [IP_W-1:0]      server_addr;
   logic [IP_W-1:0]      client_addr;
   logic [PROTO_W-1:0]   proto_num;
   int                   fail_count;

   task automatic free_slot_entry(input int i);
      slot_live[i]   = 1'b0;
      slot_req_id[i] = '0;
      slot_tries[i]  = '0;
   endtask

   task automatic predict_transaction();
      tracker_event_type ev;
      int                free_idx;
      int                top_idx;
      logic              found;
      free_idx = -1;
      top_idx  = -1;
      found    = 1'b0;
      case (req_opcode)
         OP_ISSUE: begin
            for (int i = RRT_SLOTS - 1; i >= 0; i--)
               if (!slot_live[i]) free_idx = i;
            if (free_idx < 0) begin
               ev = '{kind: KIND_FULL, slot: '0, id: id_counter, tries: '0, last: 1'b1};
            end else begin
               slot_live[free_idx]   = 1'b1;
               slot_req_id[free_idx] = id_counter;
               slot_tries[free_idx]  = TRY_W'(1);
               ev = '{kind: KIND_ALLOC, slot: SLOT_OUT_W'(free_idx), id: id_counter,
                      tries: TRY_W'(1), last: 1'b1};
               id_counter = id_counter + 1'b1;
            end
            expected_q.push_back(ev);
         end
         OP_TICK: begin
            for (int i = 0; i < RRT_SLOTS; i++)
               if (slot_live[i]) top_idx = i;
            for (int i = 0; i < RRT_SLOTS; i++) begin
               if (slot_live[i]) begin
                  if (slot_tries[i] == retry_limit) begin
                     ev = '{kind: KIND_TIMEOUT, slot: SLOT_OUT_W'(i), id: slot_req_id[i],
                            tries: '0, last: (i == top_idx)};
                     free_slot_entry(i);
                  end else begin
                     slot_tries[i] = slot_tries[i] + 1'b1;
                     ev = '{kind: KIND_RETRANSMIT, slot: SLOT_OUT_W'(i), id: slot_req_id[i],
                            tries: slot_tries[i], last: (i == top_idx)};
                  end
                  expected_q.push_back(ev);
               end
            end
         end
         OP_RESPONSE: begin
            if (req_source_address == server_addr && req_dest_address == client_addr &&
                req_proto_field == proto_num && req_is_response) begin
               for (int i = 0; i < RRT_SLOTS && !found; i++) begin
                  if (slot_live[i] && slot_req_id[i] == req_response_id) begin
                     ev = '{kind: KIND_MATCH, slot: SLOT_OUT_W'(i), id: req_response_id,
                            tries: '0, last: 1'b1};
                     expected_q.push_back(ev);
                     free_slot_entry(i);
                     found = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_result();
      tracker_event_type ev;
      if (expected_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected result: kind %0d slot %0d id %0d tries %0d last %0b",
                     rsp_kind, rsp_slot, rsp_request_id, rsp_try_count, rsp_last);
      end else begin
         ev = expected_q.pop_front();
         if (rsp_kind !== ev.kind || rsp_slot !== ev.slot || rsp_request_id !== ev.id ||
             rsp_try_count !== ev.tries || rsp_last !== ev.last) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("mismatch: expected kind %0d slot %0d id %0d tries %0d last %0b",
                        ev.kind, ev.slot, ev.id, ev.tries, ev.last);
               $display("          got kind %0d slot %0d id %0d tries %0d last %0b",
                        rsp_kind, rsp_slot, rsp_request_id, rsp_try_count, rsp_last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_q.delete();
         for (int i = 0; i < RRT_SLOTS; i++) free_slot_entry(i);
         id_counter  = RRT_FIRST_ID;
         retry_limit = RRT_LIMIT_RST;
         server_addr = '0;
         client_addr = '0;
         proto_num   = RRT_PROTO_RST;
         fail_count  = 0;
      end else begin
         if (rsp_valid) check_result();
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RETRY_LIMIT: retry_limit = csr_wr_data[TRY_W-1:0];
               CSR_SERVER_ADDR: server_addr = csr_wr_data[IP_W-1:0];
               CSR_CLIENT_ADDR: client_addr = csr_wr_data[IP_W-1:0];
               CSR_PROTOCOL:    proto_num   = csr_wr_data[PROTO_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) predict_transaction();
      end
      mismatches  <= fail_count;
      outstanding <= expected_q.size();
   end

endmodule

@@ tb/tb_retry_request_tracker.sv @@
// Top of the retry request tracker testbench: clock, reset, directed and random
// transactions, register programming and the verdict.
// Depends on rrt_pkg, retry_request_tracker and rrt_checker.
`timescale 1ns / 1ps

module tb_retry_request_tracker;
   import rrt_pkg::*;

   localparam int              CYCLE_LIMIT   = 2_000_000;
   localparam int              SETTLE_CYCLES = 2 * (RRT_SLOTS + 2) + 4;
   localparam int              PHASE_ITEMS   = 105;
   localparam logic [1:0]      OP_UNUSED     = 2'd3;
   localparam logic [ID_W-1:0] SWEEP_STOP_ID = RRT_FIRST_ID + 16'd24;

   logic                  clock;
   logic                  reset              = 1'b1;
   logic                  csr_wr_en          = 1'b0;
   logic [1:0]            csr_index          = '0;
   logic [CSR_W-1:0]      csr_wr_data        = '0;
   logic                  start              = 1'b0;
   logic                  busy;
   logic [1:0]            req_opcode         = '0;
   logic [ID_W-1:0]       req_response_id    = '0;
   logic [IP_W-1:0]       req_source_address = '0;
   logic [IP_W-1:0]       req_dest_address   = '0;
   logic [PROTO_W-1:0]    req_proto_field    = '0;
   logic                  req_is_response    = 1'b0;
   logic                  rsp_valid;
   logic [2:0]            rsp_kind;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic [ID_W-1:0]       rsp_request_id;
   logic [TRY_W-1:0]      rsp_try_count;
   logic                  rsp_last;
   int                    mismatches;
   int                    outstanding;

   int                    cycle_count = 0;
   int                    idle_pct    = 0;
   logic [ID_W-1:0]       newest_id   = RRT_FIRST_ID;
   logic [IP_W-1:0]       cfg_server  = '0;
   logic [IP_W-1:0]       cfg_client  = '0;
   logic [PROTO_W-1:0]    cfg_proto   = RRT_PROTO_RST;

   retry_request_tracker i_dut (.*);
   rrt_checker i_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (rsp_valid && rsp_kind == KIND_ALLOC) newest_id <= rsp_request_id;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // leaves start high; the caller lowers it when it idles
   task automatic send_item(input logic [1:0] op, input logic [ID_W-1:0] rid,
                            input logic [IP_W-1:0] src, input logic [IP_W-1:0] dst,
                            input logic [PROTO_W-1:0] pr, input logic rs);
      start              <= 1'b1;
      req_opcode         <= op;
      req_response_id    <= rid;
      req_source_address <= src;
      req_dest_address   <= dst;
      req_proto_field    <= pr;
      req_is_response    <= rs;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_noise(input logic [1:0] op);
      send_item(op, ID_W'($urandom()), $urandom(), $urandom(), PROTO_W'($urandom()),
                1'($urandom()));
   endtask

   task automatic drain(input int settle);
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic hold_off();
      int n;
      n = 0;
      while ($urandom_range(99) < idle_pct && n < 40) n++;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [TRY_W-1:0] lim, input logic [IP_W-1:0] srv,
                               input logic [IP_W-1:0] cli, input logic [PROTO_W-1:0] pr);
      write_reg(CSR_RETRY_LIMIT, ($urandom() & 32'hFFFF_FFF0) | CSR_W'(lim));
      write_reg(CSR_SERVER_ADDR, srv);
      write_reg(CSR_CLIENT_ADDR, cli);
      write_reg(CSR_PROTOCOL, ($urandom() & 32'hFFFF_FF00) | CSR_W'(pr));
      csr_wr_en  <= 1'b0;
      cfg_server = srv;
      cfg_client = cli;
      cfg_proto  = pr;
   endtask

   task automatic random_transaction(output logic counted);
      logic [1:0]         op;
      logic [ID_W-1:0]    rid;
      logic [IP_W-1:0]    src;
      logic [IP_W-1:0]    dst;
      logic [PROTO_W-1:0] pr;
      logic               rs;
      int                 pick;
      int                 flaw;
      pick    = $urandom_range(99);
      rid     = ID_W'($urandom());
      src     = $urandom();
      dst     = $urandom();
      pr      = PROTO_W'($urandom());
      rs      = 1'($urandom());
      counted = 1'b1;
      if (pick < 35) begin
         op = OP_ISSUE;
      end else if (pick < 55) begin
         op = OP_TICK;
      end else if (pick < 95) begin
         op   = OP_RESPONSE;
         flaw = $urandom_range(99);
         rid  = newest_id - ID_W'($urandom_range(20));
         src  = cfg_server;
         dst  = cfg_client;
         pr   = cfg_proto;
         rs   = 1'b1;
         if (flaw < 12) rid = ID_W'($urandom());
         else if (flaw < 18) src = src ^ (32'd1 << $urandom_range(31));
         else if (flaw < 24) dst = dst ^ (32'd1 << $urandom_range(31));
         else if (flaw < 30) pr = pr ^ (8'd1 << $urandom_range(7));
         else if (flaw < 36) rs = 1'b0;
      end else begin
         op      = OP_UNUSED;
         counted = 1'b0;
      end
      send_item(op, rid, src, dst, pr, rs);
   endtask

   task automatic run_phase();
      int   done;
      logic counted;
      done = 0;
      while (done < PHASE_ITEMS) begin
         hold_off();
         random_transaction(counted);
         if (counted) done++;
         if ($urandom_range(39) == 0) drain(0);
      end
      drain(SETTLE_CYCLES);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty table, unused opcode, fill to full
      send_noise(OP_TICK);
      send_noise(OP_UNUSED);
      repeat (RRT_SLOTS + 1) send_noise(OP_ISSUE);
      // match frees slot 3; filtered responses leave the table alone
      send_item(OP_RESPONSE, RRT_FIRST_ID + 16'd3, '0, '0, RRT_PROTO_RST, 1'b1);
      send_item(OP_RESPONSE, RRT_FIRST_ID + 16'd4, '0, '0, RRT_PROTO_RST, 1'b0);
      send_item(OP_RESPONSE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
      send_noise(OP_ISSUE);
      // tries climb to the reset limit, then every slot times out
      repeat (4) send_noise(OP_TICK);
      drain(SETTLE_CYCLES);

      // a few issue and match pairs on an empty table
      while (newest_id != SWEEP_STOP_ID) begin
         send_noise(OP_ISSUE);
         drain(0);
         send_item(OP_RESPONSE, newest_id, '0, '0, RRT_PROTO_RST, 1'b1);
      end
      drain(SETTLE_CYCLES);

      idle_pct = 30;
      program_regs(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      run_phase();

      // limit lowered below live try counts: those slots wrap before timing out
      idle_pct = 68;
      program_regs(4'd0, $urandom(), $urandom(), 8'h00);
      run_phase();

      idle_pct = 0;
      program_regs(4'd1, $urandom(), $urandom(), PROTO_W'($urandom()));
      run_phase();

      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
